// ----- rtl/ihc_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv4 header receive check: shared types and constants
// Verdict codes, header field positions and the per-packet state record
// that passes between the top level and the byte step logic.
// ----------------------------------------------------------------------------
package ihc_pkg;

  // Verdict codes reported on the result channel.
  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_VERSION  = 3'd1;
  localparam logic [2:0] VERDICT_HEADLEN  = 3'd2;
  localparam logic [2:0] VERDICT_TTL      = 3'd3;
  localparam logic [2:0] VERDICT_DEST     = 3'd4;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd5;

  // Header layout and limits.
  localparam logic [3:0]  IP_VERSION_4    = 4'd4;
  localparam logic [3:0]  IHL_MIN_WORDS   = 4'd5;
  localparam logic [5:0]  TTL_BYTE_IDX    = 6'd8;
  localparam logic [4:0]  CSUM_WORD_IDX   = 5'd5;
  localparam logic [5:0]  DEST_FIRST_IDX  = 6'd16;
  localparam logic [5:0]  DEST_LAST_IDX   = 6'd19;
  localparam logic [5:0]  BYTE_IDX_MAX    = 6'd63;
  localparam logic [31:0] BROADCAST_ADDR  = 32'hffff_ffff;

  // Register index, taken from bit 2 of the byte address.
  localparam logic REG_LOCAL_ADDRESS = 1'b0;

  // Per-packet working state.
  typedef struct packed {
    logic [5:0]  byte_index;
    logic [3:0]  ihl_words;
    logic [15:0] running_sum;
    logic [7:0]  high_byte;
    logic [15:0] stored_checksum;
    logic [31:0] dest_shift;
    logic        verdict_sent;
  } hdr_state_t;

  // Ones'-complement 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- rtl/ihc_hdr_step.sv -----
// ----------------------------------------------------------------------------
// IPv4 header receive check: byte step logic
// Combinational update of the packet state for one received byte, with the
// verdict that the byte decides, if any.
// ----------------------------------------------------------------------------
module ihc_hdr_step (
  input  ihc_pkg::hdr_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [31:0]         local_address,
  output ihc_pkg::hdr_state_t st_nxt,
  output logic                res_valid,
  output logic [2:0]          res_verdict,
  output logic [3:0]          res_header_words
);

  logic        found;
  logic [2:0]  verdict;
  logic [3:0]  ihl;
  logic [15:0] word;
  logic [15:0] chk;

  always_comb begin
    st_nxt  = st;
    found   = 1'b0;
    verdict = ihc_pkg::VERDICT_ACCEPT;
    ihl     = (st.byte_index == 6'd0) ? data_byte[3:0] : st.ihl_words;
    word    = {st.high_byte, data_byte};
    chk     = 16'd0;

    if (!st.verdict_sent) begin
      st_nxt.ihl_words = ihl;

      // Version and length are both judged on the first byte.
      if (st.byte_index == 6'd0) begin
        if (data_byte[7:4] != ihc_pkg::IP_VERSION_4) begin
          found   = 1'b1;
          verdict = ihc_pkg::VERDICT_VERSION;
        end else if (ihl < ihc_pkg::IHL_MIN_WORDS) begin
          found   = 1'b1;
          verdict = ihc_pkg::VERDICT_HEADLEN;
        end
      end

      if (!found && st.byte_index == ihc_pkg::TTL_BYTE_IDX && data_byte == 8'd0) begin
        found   = 1'b1;
        verdict = ihc_pkg::VERDICT_TTL;
      end

      if (!found) begin
        if (!st.byte_index[0]) begin
          st_nxt.high_byte = data_byte;
        end else if (st.byte_index[5:1] == ihc_pkg::CSUM_WORD_IDX) begin
          st_nxt.stored_checksum = word;
        end else begin
          st_nxt.running_sum = ihc_pkg::oc_add(st.running_sum, word);
        end

        if (st.byte_index >= ihc_pkg::DEST_FIRST_IDX &&
            st.byte_index <= ihc_pkg::DEST_LAST_IDX) begin
          st_nxt.dest_shift = {st.dest_shift[23:0], data_byte};
        end

        if (st.byte_index == ihc_pkg::DEST_LAST_IDX &&
            st_nxt.dest_shift != local_address &&
            st_nxt.dest_shift != ihc_pkg::BROADCAST_ADDR) begin
          found   = 1'b1;
          verdict = ihc_pkg::VERDICT_DEST;
        end
      end

      // Last header byte sits at index 4*ihl-1.
      if (!found && ihl >= ihc_pkg::IHL_MIN_WORDS &&
          st.byte_index == {ihl - 4'd1, 2'b11}) begin
        chk     = ~st_nxt.running_sum;
        found   = 1'b1;
        verdict = (chk == st_nxt.stored_checksum) ? ihc_pkg::VERDICT_ACCEPT
                                                  : ihc_pkg::VERDICT_CHECKSUM;
      end

      // A packet that ends inside its header is a length error.
      if (!found && last_byte) begin
        found   = 1'b1;
        verdict = ihc_pkg::VERDICT_HEADLEN;
      end

      if (st.byte_index < ihc_pkg::BYTE_IDX_MAX) begin
        st_nxt.byte_index = st.byte_index + 6'd1;
      end

      if (found) begin
        st_nxt.verdict_sent = 1'b1;
      end
    end

    if (last_byte) begin
      st_nxt = '0;
    end
  end

  assign res_valid        = found;
  assign res_verdict      = verdict;
  assign res_header_words = ihl;

endmodule

// ----- rtl/ipv4_header_receive_check_unit.sv -----
// ----------------------------------------------------------------------------
// IPv4 header receive check unit
// Structure: the input register holds a byte while the combinational step
// logic judges it, and the result register captures any verdict it decides.
// Throughput: one byte per cycle while the result register is free to load.
// Reset (rst_n low, synchronous): packet state, valid flags and the local
// address register return to zero.
// ----------------------------------------------------------------------------
//
// Bytes of a received packet enter through a one-entry input register. In
// the following cycle the step logic checks the byte against the packet
// state (version, header length, TTL, destination and the ones'-complement
// header checksum) and the result register captures a verdict when the byte
// is decisive. Both registers advance together whenever the result register
// is empty or its transaction completes, so a new byte is taken in every
// cycle while the result side keeps up. Bytes after a verdict are absorbed
// without producing a result until the packet's last byte, which clears the
// packet state for the next packet.
//
// The configuration port holds one register, local_address, at byte address
// zero. Bit 2 of the address selects the register; addresses with bit 2 set
// read as zero and ignore writes.
module ipv4_header_receive_check_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [3:0]  out_header_words,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration register.
  logic [31:0] local_address_r;

  // Input register.
  logic        in_valid_r;
  logic [7:0]  in_data_byte_r;
  logic        in_last_byte_r;

  // Packet state and its next value from the step logic.
  ihc_pkg::hdr_state_t state_r;
  ihc_pkg::hdr_state_t state_nxt;

  // Result register.
  logic        out_valid_r;
  logic [2:0]  out_verdict_r;
  logic [3:0]  out_header_words_r;

  logic        step_valid;
  logic [2:0]  step_verdict;
  logic [3:0]  step_header_words;
  logic        advance;
  logic        cfg_write;

  // The pipeline moves whenever the result register can take a new value.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  ihc_hdr_step u_step (
    .st               (state_r),
    .data_byte        (in_data_byte_r),
    .last_byte        (in_last_byte_r),
    .local_address    (local_address_r),
    .st_nxt           (state_nxt),
    .res_valid        (step_valid),
    .res_verdict      (step_verdict),
    .res_header_words (step_header_words)
  );

  // Input register: holds the byte until the step stage consumes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_byte_r <= in_data_byte;
      in_last_byte_r <= in_last_byte;
    end
  end

  // Packet state is updated only when a byte passes through the step stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: loaded with a verdict when the stepped byte decides one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r && step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r && step_valid) begin
      out_verdict_r      <= step_verdict;
      out_header_words_r <= step_header_words;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_header_words = out_header_words_r;

  // Configuration port: zero-wait-state transactions.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= 32'd0;
    end else if (cfg_write && cfg_paddr[2] == ihc_pkg::REG_LOCAL_ADDRESS) begin
      local_address_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ihc_pkg::REG_LOCAL_ADDRESS) ? local_address_r : 32'd0;

endmodule
